// ===== sv/crst_pkg.sv =====
// Shared types and constants for the Catmull-Rom segment tessellator.
package crst_pkg;

    localparam int COORD_W        = 24;
    localparam int DET_W          = 6;
    localparam logic [DET_W-1:0] DETAIL_RESET = 6'd20;
    localparam int MAX_DETAIL_DEF = 63;

    // Coordinate division: biased numerator, denominator 2*d^3, quotient bits.
    localparam int NUM_W    = 48;
    localparam int DEN_W    = 20;
    localparam int QUO_W    = 28;
    localparam int QUO_BIAS = 134217728;   // 2^(QUO_W-1), keeps the numerator positive

    // Blend division: numerator 2*sum+d, denominator 2*d, same quotient depth.
    localparam int BL_DEN_W = 7;
    localparam int BL_NUM_W = BL_DEN_W + QUO_W - 1;
    localparam int BL_LANES = 4;

    typedef struct packed {
        logic signed [COORD_W-1:0] p0_x;
        logic signed [COORD_W-1:0] p0_y;
        logic signed [COORD_W-1:0] p1_x;
        logic signed [COORD_W-1:0] p1_y;
        logic signed [COORD_W-1:0] p2_x;
        logic signed [COORD_W-1:0] p2_y;
        logic signed [COORD_W-1:0] p3_x;
        logic signed [COORD_W-1:0] p3_y;
        logic [23:0]               color_start;
        logic [23:0]               color_end;
        logic [7:0]                alpha_start;
        logic [7:0]                alpha_end;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic [23:0]               vertex_color;
        logic [7:0]                vertex_alpha;
        logic                      last_vertex;
    } t_out_item;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [DET_W-1:0] step;
        logic [DET_W-1:0] detail;
    } t_issue;

    typedef struct packed {
        logic [BL_LANES-1:0][BL_NUM_W-1:0] num;
        logic [BL_DEN_W-1:0]               den;
    } t_blend;

    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [1:0][NUM_W-1:0] num;
        logic [DEN_W-1:0]      den;
        t_blend                bl;
    } t_poly;

endpackage

// ===== sv/crst_seq.sv =====
// Step sequencer: latches one segment and issues steps 0..detail.
module crst_seq #(
    parameter int MAX_DETAIL = crst_pkg::MAX_DETAIL_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_in_valid,
    input  crst_pkg::t_in_item        i_in_item,
    input  logic [crst_pkg::DET_W-1:0] i_detail,
    output logic                      o_in_stall,
    output crst_pkg::t_issue          o_issue,
    output crst_pkg::t_in_item        o_item
);
    import crst_pkg::*;

    logic             r_busy;
    logic [DET_W-1:0] r_step;
    logic [DET_W-1:0] r_detail;
    t_in_item         r_item;
    logic [DET_W-1:0] n_detail;
    logic             accept;

    always_comb begin
        priority if (i_detail == '0) begin
            n_detail = DET_W'(1);
        end else if (i_detail > DET_W'(MAX_DETAIL)) begin
            n_detail = DET_W'(MAX_DETAIL);
        end else begin
            n_detail = i_detail;
        end
    end

    assign accept = i_in_valid && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (r_busy && i_en && (r_step == r_detail)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item   <= i_in_item;
            r_detail <= n_detail;
            r_step   <= '0;
        end else if (r_busy && i_en) begin
            r_step <= r_step + DET_W'(1);
        end
    end

    assign o_in_stall     = r_busy;
    assign o_issue.valid  = r_busy;
    assign o_issue.last   = (r_step == r_detail);
    assign o_issue.step   = r_step;
    assign o_issue.detail = r_detail;
    assign o_item         = r_item;

endmodule

// ===== sv/crst_poly.sv =====
// Four-stage Horner pipeline: spline numerators and blend numerators per step.
module crst_poly (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  crst_pkg::t_issue   i_issue,
    input  crst_pkg::t_in_item i_item,
    output crst_pkg::t_poly    o_poly
);
    import crst_pkg::*;

    logic signed [NUM_W-1:0] pa [2];
    logic signed [NUM_W-1:0] pb [2];
    logic signed [NUM_W-1:0] pc [2];
    logic signed [NUM_W-1:0] pe [2];
    logic [7:0]              bs [BL_LANES];
    logic [7:0]              be [BL_LANES];
    t_blend                  n1_bl;

    // stage 1
    logic                    r1_vld, r1_lst;
    logic signed [NUM_W-1:0] r1_k1 [2];
    logic signed [NUM_W-1:0] r1_k2 [2];
    logic signed [NUM_W-1:0] r1_k3 [2];
    logic signed [NUM_W-1:0] r1_b2 [2];
    logic [DET_W-1:0]        r1_i, r1_d;
    logic [2*DET_W-1:0]      r1_d2;
    t_blend                  r1_bl;
    // stage 2
    logic                    r2_vld, r2_lst;
    logic signed [NUM_W-1:0] r2_h1 [2];
    logic signed [NUM_W-1:0] r2_k1 [2];
    logic signed [NUM_W-1:0] r2_b2 [2];
    logic [DET_W-1:0]        r2_i;
    logic [2*DET_W-1:0]      r2_d2;
    logic [3*DET_W-1:0]      r2_d3;
    t_blend                  r2_bl;
    // stage 3
    logic                    r3_vld, r3_lst;
    logic signed [NUM_W-1:0] r3_h2 [2];
    logic signed [NUM_W-1:0] r3_bd [2];
    logic [DET_W-1:0]        r3_i;
    logic [3*DET_W-1:0]      r3_d3;
    t_blend                  r3_bl;
    // stage 4
    logic                    r4_vld, r4_lst;
    logic [1:0][NUM_W-1:0]   r4_num;
    logic [DEN_W-1:0]        r4_den;
    t_blend                  r4_bl;

    logic signed [DET_W:0]       s1_i, s2_i, s3_i, s1_d;
    logic signed [2*DET_W:0]     s2_d2;
    logic signed [NUM_W-1:0]     s3_d3;

    always_comb begin
        pa[0] = {{(NUM_W-COORD_W){i_item.p0_x[COORD_W-1]}}, i_item.p0_x};
        pb[0] = {{(NUM_W-COORD_W){i_item.p1_x[COORD_W-1]}}, i_item.p1_x};
        pc[0] = {{(NUM_W-COORD_W){i_item.p2_x[COORD_W-1]}}, i_item.p2_x};
        pe[0] = {{(NUM_W-COORD_W){i_item.p3_x[COORD_W-1]}}, i_item.p3_x};
        pa[1] = {{(NUM_W-COORD_W){i_item.p0_y[COORD_W-1]}}, i_item.p0_y};
        pb[1] = {{(NUM_W-COORD_W){i_item.p1_y[COORD_W-1]}}, i_item.p1_y};
        pc[1] = {{(NUM_W-COORD_W){i_item.p2_y[COORD_W-1]}}, i_item.p2_y};
        pe[1] = {{(NUM_W-COORD_W){i_item.p3_y[COORD_W-1]}}, i_item.p3_y};
        bs[0] = i_item.color_start[7:0];
        be[0] = i_item.color_end[7:0];
        bs[1] = i_item.color_start[15:8];
        be[1] = i_item.color_end[15:8];
        bs[2] = i_item.color_start[23:16];
        be[2] = i_item.color_end[23:16];
        bs[3] = i_item.alpha_start;
        be[3] = i_item.alpha_end;
    end

    // blend numerator 2*(s*(d-i) + e*i) + d, denominator 2*d
    always_comb begin
        logic [14:0] acc;
        logic [DET_W-1:0] dm;
        dm = i_issue.detail - i_issue.step;
        for (int l = 0; l < BL_LANES; l++) begin
            acc = 15'(bs[l]) * 15'(dm) + 15'(be[l]) * 15'(i_issue.step);
            n1_bl.num[l] = BL_NUM_W'({acc, 1'b0}) + BL_NUM_W'(i_issue.detail);
        end
        n1_bl.den = {i_issue.detail, 1'b0};
    end

    assign s1_i  = $signed({1'b0, r1_i});
    assign s1_d  = $signed({1'b0, r1_d});
    assign s2_i  = $signed({1'b0, r2_i});
    assign s2_d2 = $signed({1'b0, r2_d2});
    assign s3_i  = $signed({1'b0, r3_i});
    assign s3_d3 = $signed({{(NUM_W-3*DET_W){1'b0}}, r2_d3});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_issue.valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_lst <= i_issue.last;
            r1_i   <= i_issue.step;
            r1_d   <= i_issue.detail;
            r1_d2  <= i_issue.detail * i_issue.detail;
            r1_bl  <= n1_bl;
            for (int a = 0; a < 2; a++) begin
                r1_k1[a] <= pc[a] - pa[a];
                r1_k2[a] <= 48'sd2 * pa[a] - 48'sd5 * pb[a] + 48'sd4 * pc[a] - pe[a];
                r1_k3[a] <= 48'sd3 * pb[a] - pa[a] - 48'sd3 * pc[a] + pe[a];
                r1_b2[a] <= 48'sd2 * pb[a];
            end

            r2_lst <= r1_lst;
            r2_i   <= r1_i;
            r2_d2  <= r1_d2;
            r2_d3  <= (3*DET_W)'(r1_d2) * (3*DET_W)'(r1_d);
            r2_bl  <= r1_bl;
            for (int a = 0; a < 2; a++) begin
                r2_h1[a] <= r1_k3[a] * s1_i + r1_k2[a] * s1_d;
                r2_k1[a] <= r1_k1[a];
                r2_b2[a] <= r1_b2[a];
            end

            r3_lst <= r2_lst;
            r3_i   <= r2_i;
            r3_d3  <= r2_d3;
            r3_bl  <= r2_bl;
            for (int a = 0; a < 2; a++) begin
                r3_h2[a] <= r2_h1[a] * s2_i + r2_k1[a] * s2_d2;
                // 2b*d^3 plus rounding term d^3 plus floor bias 2^27 * 2d^3
                r3_bd[a] <= $signed(r2_b2[a][COORD_W:0]) * $signed({1'b0, r2_d3})
                            + s3_d3 + (s3_d3 <<< QUO_W);
            end

            r4_lst <= r3_lst;
            r4_den <= {1'b0, r3_d3, 1'b0};
            r4_bl  <= r3_bl;
            for (int a = 0; a < 2; a++) begin
                r4_num[a] <= r3_h2[a] * s3_i + r3_bd[a];
            end
        end
    end

    assign o_poly.valid = r4_vld;
    assign o_poly.last  = r4_lst;
    assign o_poly.num   = r4_num;
    assign o_poly.den   = r4_den;
    assign o_poly.bl    = r4_bl;

endmodule

// ===== sv/crst_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module crst_div #(
    parameter int NUM_W = crst_pkg::NUM_W,
    parameter int DEN_W = crst_pkg::DEN_W,
    parameter int QUO_W = crst_pkg::QUO_W
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);
    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int SH = QUO_W - 1 - s;
        logic [NUM_W-1:0] rem_in, sub, n_rem;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in, n_quo;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        always_comb begin
            sub   = NUM_W'(den_in) << SH;
            n_quo = quo_in;
            n_rem = rem_in;
            if (rem_in >= sub) begin
                n_rem     = rem_in - sub;
                n_quo[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_den[s] <= den_in;
                r_quo[s] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// ===== sv/catmull_rom_segment_tessellator.sv =====
// Top level of the Catmull-Rom segment tessellator.
//
// Input channel: one item is one segment (four control points, colors,
// alphas), taken when i_in_valid is high and o_in_stall is low. Output
// channel: one item per vertex, detail+1 of them per segment, taken when
// o_out_valid is high and i_out_stall is low; last_vertex marks the end.
// Configuration: i_cfg_wr_en writes detail (0 acts as 1, values above
// MAX_DETAIL clamp). Write only while the block is idle; each segment
// latches detail when it is accepted.
//
// Throughput: at most one vertex per cycle, and none while the receiver stalls;
// input is stalled while the step sequencer works through a segment's steps,
// so a new segment is taken only once the previous one has issued its last step.
// Path: after the accepting edge the sequencer issues step 0, which passes
// four polynomial stages, a 28-stage divider and the output register before
// the first vertex of the segment reaches the output.
// Reset: sequencer idle, pipeline empty, detail back to 20.
// Stall: while the output register holds an untaken vertex and the receiver
// stalls, the whole pipeline and the sequencer's stepping freeze; nothing is dropped.
module catmull_rom_segment_tessellator #(
    parameter int MAX_DETAIL = crst_pkg::MAX_DETAIL_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  crst_pkg::t_in_item         i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output crst_pkg::t_out_item        o_out_item,
    input  logic                       i_cfg_wr_en,
    input  logic [crst_pkg::DET_W-1:0] i_cfg_wr_data
);
    import crst_pkg::*;

    logic [DET_W-1:0] r_detail;
    logic             en;
    t_issue           issue;
    t_in_item         item;
    t_poly            poly;

    logic [QUO_W-1:0] quo_c  [2];
    logic [QUO_W-1:0] quo_b  [BL_LANES];
    logic             r_cv   [QUO_W];
    logic             r_cl   [QUO_W];
    logic             r_out_valid;
    t_out_item        r_out;
    t_out_item        n_out;

    // global advance: hold everything while a vertex waits on a stalled receiver
    assign en = !(r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detail <= DETAIL_RESET;
        end else if (i_cfg_wr_en) begin
            r_detail <= i_cfg_wr_data;
        end
    end

    crst_seq #(.MAX_DETAIL(MAX_DETAIL)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .i_detail   (r_detail),
        .o_in_stall (o_in_stall),
        .o_issue    (issue),
        .o_item     (item)
    );

    crst_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_issue (issue),
        .i_item  (item),
        .o_poly  (poly)
    );

    // x and y: floor((num + d^3) / (2 d^3)) with a positive bias folded in
    for (genvar a = 0; a < 2; a++) begin : g_coord
        crst_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .QUO_W(QUO_W)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (poly.num[a]),
            .i_den (poly.den),
            .o_quo (quo_c[a])
        );
    end

    // color bytes and alpha; same depth keeps the lanes aligned
    for (genvar l = 0; l < BL_LANES; l++) begin : g_blend
        crst_div #(.NUM_W(BL_NUM_W), .DEN_W(BL_DEN_W), .QUO_W(QUO_W)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (poly.bl.num[l]),
            .i_den (poly.bl.den),
            .o_quo (quo_b[l])
        );
    end

    // valid and last ride alongside the divider stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QUO_W; s++) begin
                r_cv[s] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_cv[0] <= poly.valid;
            for (int s = 1; s < QUO_W; s++) begin
                r_cv[s] <= r_cv[s-1];
            end
            r_out_valid <= r_cv[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cl[0] <= poly.last;
            for (int s = 1; s < QUO_W; s++) begin
                r_cl[s] <= r_cl[s-1];
            end
            r_out <= n_out;
        end
    end

    // remove the bias and saturate to the coordinate range (signed compares)
    always_comb begin
        logic signed [QUO_W:0] v;
        logic signed [COORD_W-1:0] sat [2];
        for (int a = 0; a < 2; a++) begin
            v = $signed({1'b0, quo_c[a]}) - $signed((QUO_W+1)'(QUO_BIAS));
            priority if (v > $signed((QUO_W+1)'(8388607))) begin
                sat[a] = 24'sh7FFFFF;
            end else if (v < -$signed((QUO_W+1)'(8388608))) begin
                sat[a] = 24'sh800000;
            end else begin
                sat[a] = v[COORD_W-1:0];
            end
        end
        n_out.vertex_x     = sat[0];
        n_out.vertex_y     = sat[1];
        n_out.vertex_color = {quo_b[2][7:0], quo_b[1][7:0], quo_b[0][7:0]};
        n_out.vertex_alpha = quo_b[3][7:0];
        n_out.last_vertex  = r_cl[QUO_W-1];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
